[design/kpc_pkg.sv]
package kpc_pkg;

  localparam int unsigned KeyCount  = 2;
  localparam int unsigned KeyIdxW   = (KeyCount > 1) ? $clog2(KeyCount) : 1;
  localparam int unsigned SlotCount = 2 * KeyCount;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned HistW     = 8;
  localparam int unsigned HoldW     = 9;
  localparam int unsigned ThreshW   = 8;

  localparam logic [HistW-1:0]   PatPress    = 8'h0f;
  localparam logic [HistW-1:0]   PatHeld     = 8'hff;
  localparam logic [HistW-1:0]   PatRelease  = 8'hf0;
  localparam logic [ThreshW-1:0] ThreshReset = 8'd100;
  localparam logic [HoldW-1:0]   HoldSat     = 9'd256;
  localparam logic [HoldW-1:0]   DropAfter   = 9'd2;

  typedef enum logic [1:0] {
    EvDown = 2'd0,
    EvLong = 2'd1,
    EvUp   = 2'd2
  } event_kind_e;

  // per key events of one tick: first is always a short press down
  typedef struct packed {
    logic        first_v;
    logic        second_v;
    event_kind_e second_kind;
  } lane_ev_t;

endpackage

[design/kpc_lane.sv]
module kpc_lane
  import kpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic               level_i,
  input  logic [ThreshW-1:0] thresh_i,
  output lane_ev_t           ev_o
);

  logic [HistW-1:0] hist_q, hist_d;
  logic             pend_q, pend_d;
  logic [HoldW-1:0] cnt_q, cnt_d;
  logic [HoldW-1:0] cnt_inc;
  logic [HoldW-1:0] thresh_ext;

  assign cnt_inc    = cnt_q + HoldW'(1);
  assign thresh_ext = {1'b0, thresh_i};

  always_comb begin
    hist_d = {hist_q[HistW-2:0], level_i};
    pend_d = pend_q;
    cnt_d  = cnt_q;
    ev_o   = '0;
    ev_o.second_kind = EvUp;
    priority if (hist_d == PatPress) begin
      pend_d = 1'b1;
    end else if (hist_d == PatHeld) begin
      cnt_d = cnt_inc;
      priority if (cnt_inc == thresh_ext) begin
        ev_o.second_v    = 1'b1;
        ev_o.second_kind = EvLong;
      end else if (cnt_inc > thresh_ext) begin
        cnt_d = HoldSat;
      end else if (cnt_inc > DropAfter) begin
        pend_d = 1'b0;
      end else begin
      end
    end else if (hist_d == PatRelease) begin
      cnt_d = '0;
      if (pend_q) begin
        pend_d        = 1'b0;
        ev_o.first_v  = 1'b1;
      end
      ev_o.second_v    = 1'b1;
      ev_o.second_kind = EvUp;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      hist_q <= hist_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[design/kpc_merge.sv]
module kpc_merge
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  lane_ev_t            ev_i [KeyCount],
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KeyIdxW-1:0]  key_index_o,
  output logic [1:0]          event_kind_o,
  output logic                last_o
);

  logic [SlotCount-1:0] pend_q, pend_d;
  logic [SlotCount-1:0] new_mask;
  logic [SlotCount-1:0] rest;
  event_kind_e          skind_q [KeyCount];
  logic [SlotW-1:0]     sel;
  logic                 found;
  logic                 load;
  logic [KeyIdxW-1:0]   sel_key;
  logic                 out_valid_q, out_valid_d;
  logic [KeyIdxW-1:0]   key_q;
  event_kind_e          kind_q;
  logic                 last_q;

  always_comb begin
    for (int k = 0; k < KeyCount; k++) begin
      new_mask[2*k]   = ev_i[k].first_v;
      new_mask[2*k+1] = ev_i[k].second_v;
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int s = 0; s < SlotCount; s++) begin
      if (!found && pend_q[s]) begin
        sel   = SlotW'(s);
        found = 1'b1;
      end
    end
  end

  assign sel_key     = KeyIdxW'(sel >> 1);
  assign rest        = pend_q & ~(SlotCount'(1) << sel);
  assign load        = found && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !found || (load && (rest == '0));
  assign pend_d      = (load ? rest : pend_q) | (fire_i ? new_mask : '0);
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int k = 0; k < KeyCount; k++) begin
        skind_q[k] <= ev_i[k].second_kind;
      end
    end
    if (load) begin
      key_q  <= sel_key;
      kind_q <= sel[0] ? skind_q[sel_key] : EvDown;
      last_q <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = key_q;
  assign event_kind_o = kind_q;
  assign last_o       = last_q;

  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> ($countones(pend_q) <= 1))
    else $error("tick taken while older events still queued");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (rest != '0)) |=> !last_q)
    else $error("last set with events of the tick still pending");

  a_events_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (new_mask != '0)) |=> (pend_q != '0) || out_valid_q)
    else $error("events of a tick were dropped");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> ((load ? rest : pend_q) == '0))
    else $error("new tick merged into an unfinished batch");

endmodule

[design/key_press_classifier_core.sv]
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------
// in       | in_valid_i / in_ready_o    | key_levels_i
// out      | out_valid_o / out_ready_i  | key_index_o, event_kind_o, last_o
// cfg      | cfg_we_i                   | cfg_wdata_i (long press ticks)
//
// all keys are classified in parallel in the cycle a tick is taken
// a tick causing events holds the input until the output register has drained
// the event queue, one item per cycle unless out_ready_i stalls it
// the next tick is taken in the cycle the last queued event is loaded
// reset clears histories, hold counters, pending flags and the queue;
// threshold resets to 100
module key_press_classifier_core
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ThreshW-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KeyCount-1:0] key_levels_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KeyIdxW-1:0]  key_index_o,
  output logic [1:0]          event_kind_o,
  output logic                last_o
);

  logic [ThreshW-1:0] thresh_q;
  logic               fire;
  lane_ev_t           lane_ev [KeyCount];

  assign fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  for (genvar k = 0; k < KeyCount; k++) begin : g_lane
    kpc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .fire_i   (fire),
      .level_i  (key_levels_i[k]),
      .thresh_i (thresh_q),
      .ev_o     (lane_ev[k])
    );
  end

  kpc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .ev_i         (lane_ev),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_index_o  (key_index_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o)
  );

endmodule
